// ----- design/cbe_pkg.sv -----
// shared types and constants for the cubic bezier evaluator
// no dependencies; imported by every module of the block except cbe_fifo
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int COORD_W   = 16;
  localparam int T_W       = 17;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 8;

  // 1.0 in the 16 fraction bit format of the curve parameter
  localparam logic [T_W-1:0] ONE_FX = 17'h10000;

  // stages of the per-axis interpolation pipeline
  localparam int AXIS_LAT  = 10;
  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 16;

  // opcodes
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_ONE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_ONE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_TWO_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_TWO_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_Y   = 3'd7;

  typedef struct packed {
    logic           opcode;
    logic [T_W-1:0] curve_param;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [IDX_W-1:0]          point_index;
    logic                      last_point;
  } out_item_t;

  // one curve point to evaluate, handed from front to back
  typedef struct packed {
    logic [T_W-1:0]   t;
    logic [IDX_W-1:0] index;
    logic             last;
  } job_t;

endpackage

// ----- design/cbe_fifo.sv -----
// small generic queue in flip-flops, combinational head read
// no dependencies
`timescale 1ns / 1ps

module cbe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = push & ~full;
  assign pop_ok   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/cbe_front.sv -----
// front end: accepts items, clamps t, expands a sweep into point jobs
// depends on cbe_pkg
`timescale 1ns / 1ps

module cbe_front #(
  parameter int POINT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  cbe_pkg::in_item_t in_data,
  output logic              in_full,
  output logic              job_push,
  output cbe_pkg::job_t     job_data,
  input  logic              job_full
);

  import cbe_pkg::*;

  localparam int Denom = POINT_COUNT - 1;
  localparam logic [T_W-1:0]   STEP_Q   = T_W'(65536 / Denom);
  localparam logic [IDX_W-1:0] STEP_R   = IDX_W'(65536 % Denom);
  localparam logic [IDX_W-1:0] DENOM_V  = IDX_W'(Denom);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINT_COUNT - 1);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic             accept;
  logic             sweep_push;
  logic [T_W-1:0]   t_clamped;
  logic [IDX_W:0]   rem_sum;

  assign in_full    = busy_r | job_full;
  assign accept     = in_push & ~in_full;
  assign sweep_push = busy_r & ~job_full;
  assign job_push   = sweep_push | (accept & (in_data.opcode == OP_EVAL));

  // anything above 1.0 saturates to 1.0
  assign t_clamped = (in_data.curve_param[T_W-1] && (|in_data.curve_param[T_W-2:0])) ?
                     ONE_FX : in_data.curve_param;

  always_comb begin
    if (busy_r) begin
      job_data.t     = t_r;
      job_data.index = idx_r;
      job_data.last  = (idx_r == LAST_IDX);
    end else begin
      job_data.t     = t_clamped;
      job_data.index = '0;
      job_data.last  = 1'b1;
    end
  end

  // t steps by 65536/(n-1) with the remainder carried, so t(i) is exact
  assign rem_sum = {1'b0, rem_r} + {1'b0, STEP_R};

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    t_nxt    = t_r;
    rem_nxt  = rem_r;
    if (accept && (in_data.opcode == OP_SWEEP)) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      t_nxt    = '0;
      rem_nxt  = '0;
    end else if (sweep_push) begin
      idx_nxt = idx_r + 1'b1;
      if (rem_sum >= {1'b0, DENOM_V}) begin
        rem_nxt = IDX_W'(rem_sum - {1'b0, DENOM_V});
        t_nxt   = t_r + STEP_Q + 1'b1;
      end else begin
        rem_nxt = IDX_W'(rem_sum);
        t_nxt   = t_r + STEP_Q;
      end
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      t_r    <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      t_r    <= t_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ----- design/cbe_axis.sv -----
// de casteljau pipeline for one axis, fixed latency, always advancing
// depends on cbe_pkg
`timescale 1ns / 1ps

module cbe_axis (
  input  logic                                clk,
  input  logic signed [cbe_pkg::COORD_W-1:0] ctrl [4],
  input  logic [cbe_pkg::T_W-1:0]            t_in,
  output logic signed [cbe_pkg::COORD_W-1:0] coord
);

  import cbe_pkg::*;

  logic [T_W-1:0]     t_r [7];
  logic signed [16:0] d1_r [3];
  logic signed [34:0] m1_r [3];
  logic signed [31:0] q_r [3];
  logic signed [32:0] d2_r [2];
  logic signed [31:0] qc4_r [2];
  logic signed [31:0] qc5_r [2];
  logic signed [34:0] m2_r [2];
  logic signed [31:0] r_r [2];
  logic signed [32:0] d3_r;
  logic signed [31:0] rc7_r, rc8_r;
  logic signed [34:0] m3_r;
  logic signed [31:0] v_r;
  logic signed [COORD_W-1:0] coord_r;

  logic signed [34:0] q_sum [3];
  logic signed [50:0] m2_full [2];
  logic signed [34:0] r_sum [2];
  logic signed [50:0] m3_full;
  logic signed [34:0] v_sum;
  logic signed [32:0] v_round;
  logic signed [16:0] px;
  logic signed [COORD_W-1:0] px_sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // first level: anchors are whole pixels, so the lerp is exact
      q_sum[k] = 35'($signed({ctrl[k], 16'h0000})) + m1_r[k];
    end
    for (int k = 0; k < 2; k++) begin
      m2_full[k] = d2_r[k] * $signed({1'b0, t_r[3]});
      r_sum[k]   = 35'(qc5_r[k]) + m2_r[k];
    end
    m3_full = d3_r * $signed({1'b0, t_r[6]});
    v_sum   = 35'(rc8_r) + m3_r;
    // round half up, then clamp to 16 bits
    v_round = 33'(v_r) + 33'sd32768;
    px      = v_round[32:16];
    if (px > 17'sd32767) begin
      px_sat = 16'sh7fff;
    end else if (px < -17'sd32768) begin
      px_sat = 16'sh8000;
    end else begin
      px_sat = px[15:0];
    end
  end

  always_ff @(posedge clk) begin
    t_r[0] <= t_in;
    for (int s = 1; s < 7; s++) begin
      t_r[s] <= t_r[s-1];
    end
    for (int k = 0; k < 3; k++) begin
      d1_r[k] <= 17'(ctrl[k+1]) - 17'(ctrl[k]);
      m1_r[k] <= d1_r[k] * $signed({1'b0, t_r[0]});
      q_r[k]  <= q_sum[k][31:0];
    end
    for (int k = 0; k < 2; k++) begin
      d2_r[k]  <= 33'(q_r[k+1]) - 33'(q_r[k]);
      qc4_r[k] <= q_r[k];
      qc5_r[k] <= qc4_r[k];
      // arithmetic shift right by 16 is the floor division
      m2_r[k]  <= m2_full[k][50:16];
      r_r[k]   <= r_sum[k][31:0];
    end
    d3_r    <= 33'(r_r[1]) - 33'(r_r[0]);
    rc7_r   <= r_r[0];
    rc8_r   <= rc7_r;
    m3_r    <= m3_full[50:16];
    v_r     <= v_sum[31:0];
    coord_r <= px_sat;
  end

  assign coord = coord_r;

endmodule

// ----- design/cbe_back.sv -----
// back end: issues jobs into both axis pipelines, queues finished points
// depends on cbe_pkg, cbe_axis, cbe_fifo
`timescale 1ns / 1ps

module cbe_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                job_empty,
  input  cbe_pkg::job_t                       job_data,
  output logic                                job_pop,
  input  logic signed [cbe_pkg::COORD_W-1:0] ctrl_x [4],
  input  logic signed [cbe_pkg::COORD_W-1:0] ctrl_y [4],
  output logic                                out_empty,
  input  logic                                out_pop,
  output cbe_pkg::out_item_t                  out_data
);

  import cbe_pkg::*;

  localparam int USED_W = $clog2(RES_DEPTH + 1);

  logic [USED_W-1:0] used_r, used_nxt;
  logic              issue;
  logic              pop_ok;
  logic              valid_r [AXIS_LAT];
  logic [IDX_W-1:0]  idx_r [AXIS_LAT];
  logic              last_r [AXIS_LAT];
  logic signed [COORD_W-1:0] x_val, y_val;
  out_item_t         res_item;
  logic              res_full;

  // a slot in the result queue is reserved at issue, freed at pop
  assign issue   = ~job_empty & (used_r < USED_W'(RES_DEPTH));
  assign job_pop = issue;
  assign pop_ok  = out_pop & ~out_empty;

  always_comb begin
    used_nxt = used_r;
    if (issue && !pop_ok) begin
      used_nxt = used_r + 1'b1;
    end else if (pop_ok && !issue) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int s = 0; s < AXIS_LAT; s++) begin
        valid_r[s] <= 1'b0;
      end
    end else begin
      used_r     <= used_nxt;
      valid_r[0] <= issue;
      for (int s = 1; s < AXIS_LAT; s++) begin
        valid_r[s] <= valid_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0]  <= job_data.index;
    last_r[0] <= job_data.last;
    for (int s = 1; s < AXIS_LAT; s++) begin
      idx_r[s]  <= idx_r[s-1];
      last_r[s] <= last_r[s-1];
    end
  end

  cbe_axis u_axis_x (
    .clk   (clk),
    .ctrl  (ctrl_x),
    .t_in  (job_data.t),
    .coord (x_val)
  );

  cbe_axis u_axis_y (
    .clk   (clk),
    .ctrl  (ctrl_y),
    .t_in  (job_data.t),
    .coord (y_val)
  );

  always_comb begin
    res_item.point_x     = x_val;
    res_item.point_y     = y_val;
    res_item.point_index = idx_r[AXIS_LAT-1];
    res_item.last_point  = last_r[AXIS_LAT-1];
  end

  cbe_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (valid_r[AXIS_LAT-1]),
    .push_data (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  // the credit count keeps the result queue from ever overflowing
  always_ff @(posedge clk) begin
    if (rst_n && valid_r[AXIS_LAT-1] && res_full) begin
      $error("result queue overflow");
    end
  end

endmodule

// ----- design/cubic_bezier_evaluator_unit.sv -----
// cubic bezier evaluator: single point at t = 1 beat in, 1 beat out; a sweep gives
// POINT_COUNT beats at one per cycle while the job and result queues have room, and the next
// item is accepted only once the front end job sequencer has expanded the whole sweep.
// the 10-stage interpolation pipeline per axis accepts one point per cycle.
// synchronous active-low reset clears the control points to zero and empties all queues.
`timescale 1ns / 1ps

module cubic_bezier_evaluator_unit #(
  parameter int POINT_COUNT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  cbe_pkg::in_item_t                 in_data,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output cbe_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbe_pkg::COORD_W-1:0]       cfg_wdata
);

  import cbe_pkg::*;

  logic signed [COORD_W-1:0] cfg_r [NUM_REGS];
  logic signed [COORD_W-1:0] ctrl_x [4];
  logic signed [COORD_W-1:0] ctrl_y [4];
  logic  job_push, job_full, job_pop, job_empty;
  job_t  job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  assign ctrl_x[0] = cfg_r[REG_START_X];
  assign ctrl_x[1] = cfg_r[REG_PULL_ONE_X];
  assign ctrl_x[2] = cfg_r[REG_PULL_TWO_X];
  assign ctrl_x[3] = cfg_r[REG_FINISH_X];
  assign ctrl_y[0] = cfg_r[REG_START_Y];
  assign ctrl_y[1] = cfg_r[REG_PULL_ONE_Y];
  assign ctrl_y[2] = cfg_r[REG_PULL_TWO_Y];
  assign ctrl_y[3] = cfg_r[REG_FINISH_Y];

  cbe_front #(
    .POINT_COUNT (POINT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  cbe_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  cbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .ctrl_x    (ctrl_x),
    .ctrl_y    (ctrl_y),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // the front never pushes a job into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
    else $error("job pushed into full queue");

  // a single evaluation turns into exactly one job in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.opcode == OP_EVAL) |-> job_push)
    else $error("accepted evaluation produced no job");

  // once a sweep is taken the input side holds off until it is expanded
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.opcode == OP_SWEEP) |=> in_full)
    else $error("input taken during sweep expansion");

endmodule
